/* rtl/linear_resampler_with_downmix_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef LINEAR_RESAMPLER_WITH_DOWNMIX_UNIT_ASSERT_SVH
`define LINEAR_RESAMPLER_WITH_DOWNMIX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRDM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrdm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrdm assertion failed");

`endif

/* rtl/lrdm_pkg.sv */
`timescale 1ns / 1ps
package lrdm_pkg;

    localparam int RATE_W     = 18;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_W      = 34;
    localparam int MAX_RESULTS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_DOWNMIX = 2'd2;

    localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd44100;
    localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;
    localparam logic              DOWNMIX_RST  = 1'b1;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic frame;
        logic flush_clear;
        logic flush_out;
        logic mul;
        logic div_step;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic frame_run;
        logic flush_emit;
        logic out_free;
        logic div_done;
        logic last;
        logic need_mod;
    } t_sts;

endpackage

/* rtl/lrdm_ctrl.sv */
`timescale 1ns / 1ps
module lrdm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    input  lrdm_pkg::t_sts    i_sts,
    output lrdm_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FLUSH = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_MOD   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == lrdm_pkg::REQ_FLUSH) begin
                        if (i_sts.flush_emit) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_cmd.flush_clear = 1'b1;
                        end
                    end else begin
                        o_cmd.frame = 1'b1;
                        if (i_sts.frame_run) begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_sts.last) begin
                        n_state = S_MUL;
                    end else if (i_sts.need_mod) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lrdm_dp.sv */
`timescale 1ns / 1ps
module lrdm_dp #(
    parameter int MAX_RESULTS = lrdm_pkg::MAX_RESULTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lrdm_pkg::t_cmd                        i_cmd,
    output lrdm_pkg::t_sts                        o_sts,
    input  logic signed [lrdm_pkg::SAMPLE_W-1:0]  i_sample_left,
    input  logic signed [lrdm_pkg::SAMPLE_W-1:0]  i_sample_right,
    input  logic                                  i_cfg_write,
    input  logic [lrdm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lrdm_pkg::RATE_W-1:0]           i_cfg_data,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [lrdm_pkg::SAMPLE_W-1:0]  o_out_left,
    output logic signed [lrdm_pkg::SAMPLE_W-1:0]  o_out_right,
    output logic                                  o_last_of_run
);

    localparam int RW = lrdm_pkg::RATE_W;
    localparam int SW = lrdm_pkg::SAMPLE_W;
    localparam int DW = lrdm_pkg::DIV_W;
    localparam int CW = $clog2(MAX_RESULTS + 1);
    localparam int DCW = $clog2(DW);

    // configuration
    logic [RW-1:0] r_in_rate;
    logic [RW-1:0] r_out_rate;
    logic          r_downmix;

    // converter state
    logic [SW-1:0] r_prev;
    logic          r_have;
    logic [RW-1:0] r_phase;

    // run state
    logic [SW-1:0]  r_cur;
    logic [RW-1:0]  r_t;
    logic [CW-1:0]  r_cnt;
    logic           r_neg;

    // shared restoring divider
    logic [DW-1:0]  r_quo;
    logic [RW-1:0]  r_rem;
    logic [DCW-1:0] r_div_cnt;
    logic           r_div_mod;

    // output register
    logic          r_out_valid;
    logic [SW-1:0] r_out_left;
    logic          r_out_last;

    logic [SW:0]     sum_lr;
    logic [SW:0]     sum_rnd;
    logic [SW-1:0]   cur;
    logic [SW:0]     delta;
    logic [SW:0]     mag;
    logic [DW:0]     prod_full;
    logic [RW-1:0]   divisor;
    logic [RW:0]     rem_sh;
    logic            rem_ge;
    logic [RW:0]     rem_sub;
    logic [RW-1:0]   rem_nx;
    logic [RW:0]     t_next;
    logic            ticks_done;
    logic            cap_hit;
    logic [SW:0]     q_mag;
    logic [SW+1:0]   q_signed;
    logic [SW+1:0]   interp;
    logic            rates_ok;
    logic            out_free;

    // (l + r) / 2 truncating toward zero
    assign sum_lr  = {i_sample_left[SW-1], i_sample_left} + {i_sample_right[SW-1], i_sample_right};
    assign sum_rnd = sum_lr + {{SW{1'b0}}, sum_lr[SW]};
    assign cur     = r_downmix ? sum_rnd[SW:1] : i_sample_left;

    assign delta     = {r_cur[SW-1], r_cur} - {r_prev[SW-1], r_prev};
    assign mag       = delta[SW] ? (~delta + 1'b1) : delta;
    assign prod_full = {{(DW-SW){1'b0}}, mag} * {{(DW+1-RW){1'b0}}, r_t};

    assign divisor = r_div_mod ? r_in_rate : r_out_rate;
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, divisor});
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign rem_nx  = rem_ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];

    assign t_next     = {1'b0, r_t} + {1'b0, r_in_rate};
    assign ticks_done = (t_next >= {1'b0, r_out_rate});
    assign cap_hit    = ((r_cnt + 1'b1) == CW'(MAX_RESULTS));

    assign q_mag    = r_quo[SW:0];
    assign q_signed = r_neg ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};
    assign interp   = {{2{r_prev[SW-1]}}, r_prev} + q_signed;

    assign rates_ok = (r_in_rate != '0) && (r_out_rate != '0);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.frame_run  = rates_ok && r_have && (r_phase < r_out_rate);
    assign o_sts.flush_emit = r_have && (r_phase == '0);
    assign o_sts.out_free   = out_free;
    assign o_sts.div_done   = (r_div_cnt == DCW'(DW - 1));
    assign o_sts.last       = ticks_done || cap_hit;
    assign o_sts.need_mod   = !ticks_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate  <= lrdm_pkg::IN_RATE_RST;
            r_out_rate <= lrdm_pkg::OUT_RATE_RST;
            r_downmix  <= lrdm_pkg::DOWNMIX_RST;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                lrdm_pkg::CFG_INPUT_RATE:     r_in_rate  <= i_cfg_data;
                lrdm_pkg::CFG_OUTPUT_RATE:    r_out_rate <= i_cfg_data;
                lrdm_pkg::CFG_STEREO_DOWNMIX: r_downmix  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_phase <= '0;
        end else begin
            if (i_cmd.flush_clear || i_cmd.flush_out) begin
                r_prev  <= '0;
                r_have  <= 1'b0;
                r_phase <= '0;
            end
            if (i_cmd.frame && rates_ok) begin
                if (!r_have) begin
                    r_prev <= cur;
                    r_have <= 1'b1;
                end else if (r_phase >= r_out_rate) begin
                    r_phase <= r_phase - r_out_rate;
                    r_prev  <= cur;
                end
            end
            if (i_cmd.emit && o_sts.last && ticks_done) begin
                r_phase <= t_next[RW-1:0] - r_out_rate;
                r_prev  <= r_cur;
            end
            if (i_cmd.finish) begin
                r_phase <= (r_rem == '0) ? '0 : (r_in_rate - r_rem);
                r_prev  <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame) begin
            r_cur <= cur;
            r_t   <= r_phase;
            r_cnt <= '0;
        end
        if (i_cmd.mul) begin
            r_quo     <= prod_full[DW-1:0];
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_div_mod <= 1'b0;
            r_neg     <= delta[SW];
        end
        if (i_cmd.div_step) begin
            r_quo     <= {r_quo[DW-2:0], rem_ge};
            r_rem     <= rem_nx;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.emit) begin
            r_t   <= t_next[RW-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (o_sts.last && !ticks_done) begin
                r_quo     <= {{(DW-RW){1'b0}}, r_out_rate - t_next[RW-1:0]};
                r_rem     <= '0;
                r_div_cnt <= '0;
                r_div_mod <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.flush_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_left <= interp[SW-1:0];
            r_out_last <= o_sts.last;
        end else if (i_cmd.flush_out) begin
            r_out_left <= r_prev;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_left    = r_out_left;
    assign o_out_right   = r_out_left;
    assign o_last_of_run = r_out_last;

endmodule

/* rtl/linear_resampler_with_downmix_unit.sv */
`timescale 1ns / 1ps
// Linear-interpolation sample rate converter with optional stereo downmix. One input item
// is taken at a time. A frame first takes the item, then per result does a multiply, 34
// steps of a shared restoring divider and an output load, which waits while a result
// is stalled in the output register. A run capped at MAX_RESULTS adds one more pass of
// the same divider plus a phase update, to recompute the phase. Results sit in an output
// register, so the next item is taken while the final result of a run still waits.
// Configuration writes are always ready and should only be issued while the block is idle.
module linear_resampler_with_downmix_unit #(
    parameter int MAX_RESULTS = lrdm_pkg::MAX_RESULTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic signed [lrdm_pkg::SAMPLE_W-1:0]  i_sample_left,
    input  logic signed [lrdm_pkg::SAMPLE_W-1:0]  i_sample_right,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [lrdm_pkg::SAMPLE_W-1:0]  o_out_left,
    output logic signed [lrdm_pkg::SAMPLE_W-1:0]  o_out_right,
    output logic                                  o_last_of_run,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lrdm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lrdm_pkg::RATE_W-1:0]           i_cfg_data
);

    lrdm_pkg::t_cmd cmd;
    lrdm_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    lrdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lrdm_dp #(
        .MAX_RESULTS (MAX_RESULTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

/* rtl/lrdm_checker.sv */
`timescale 1ns / 1ps
`include "linear_resampler_with_downmix_unit_assert.svh"
module lrdm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_stall,
    input logic                          i_out_valid,
    input logic                          i_out_stall,
    input logic [lrdm_pkg::SAMPLE_W-1:0] i_out_left,
    input logic [lrdm_pkg::SAMPLE_W-1:0] i_out_right,
    input logic                          i_last_of_run
);

    // both channels carry the same mono sample
    `LRDM_ASSERT_SAME(a_mono_out, i_clk, i_rst_n, i_out_valid, i_out_left == i_out_right)

    // a stalled result holds
    `LRDM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_left) && $stable(i_last_of_run))

    // mid-run results mean the block is still busy with that item
    `LRDM_ASSERT_SAME(a_busy_mid_run, i_clk, i_rst_n, i_out_valid && !i_last_of_run, i_in_stall)

endmodule

bind linear_resampler_with_downmix_unit lrdm_checker u_lrdm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_stall    (o_in_stall),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_out_left    (o_out_left),
    .i_out_right   (o_out_right),
    .i_last_of_run (o_last_of_run)
);
